// ----- sv/rgb_pixel_blend_unit_core_assert.svh -----
// assertion macros shared by the checker files
`ifndef RGB_PIXEL_BLEND_UNIT_CORE_ASSERT_SVH
`define RGB_PIXEL_BLEND_UNIT_CORE_ASSERT_SVH

// same-cycle implication, quiet while reset is high
`define RPB_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// implication checked on the next edge
`define RPB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// delayed implication
`define RPB_ASSERT_LATER2(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##2 (cons)) \
      else $error(msg);

`endif

// ----- sv/rpb_pkg.sv -----
`default_nettype none
package rpb_pkg;

   localparam int RPB_CHAN_W     = 8;
   localparam int RPB_PROD_W     = 2 * RPB_CHAN_W;
   localparam int RPB_NUM_W      = RPB_PROD_W + 1;
   localparam int RPB_LANES      = 3;
   localparam int RPB_FIFO_DEPTH = 4;
   localparam int RPB_PTR_W      = $clog2(RPB_FIFO_DEPTH);
   localparam int RPB_CNT_W      = RPB_PTR_W + 1;

   localparam logic [RPB_CHAN_W-1:0] RPB_FULL_SCALE = 8'd255;
   localparam logic [RPB_CHAN_W-1:0] RPB_HALF_SCALE = 8'd127;

   typedef enum logic [1:0] {
      RPB_OP_MULTIPLY = 2'd0,
      RPB_OP_SUBTRACT = 2'd1,
      RPB_OP_SCREEN   = 2'd2,
      RPB_OP_OVERLAY  = 2'd3
   } op_type;

   // how a lane finishes its product in the second stage
   typedef enum logic [2:0] {
      RPB_FORM_MUL    = 3'd0,
      RPB_FORM_SUB    = 3'd1,
      RPB_FORM_SCR    = 3'd2,
      RPB_FORM_OVL_LO = 3'd3,
      RPB_FORM_OVL_HI = 3'd4
   } form_type;

endpackage
`default_nettype wire

// ----- sv/rpb_lane.sv -----
`default_nettype none
module rpb_lane (
   input  wire logic                           clock,
   input  wire logic                           enable,
   input  wire rpb_pkg::op_type                op,
   input  wire logic [rpb_pkg::RPB_CHAN_W-1:0] top_chan,
   input  wire logic [rpb_pkg::RPB_CHAN_W-1:0] bottom_chan,
   output logic      [rpb_pkg::RPB_CHAN_W-1:0] result
);

   logic [rpb_pkg::RPB_CHAN_W-1:0] opnd_x;
   logic [rpb_pkg::RPB_CHAN_W-1:0] opnd_y;
   rpb_pkg::form_type              form_in;
   logic [rpb_pkg::RPB_PROD_W-1:0] prod_in;
   logic [rpb_pkg::RPB_CHAN_W-1:0] diff_in;

   rpb_pkg::form_type              form_ff;
   logic [rpb_pkg::RPB_PROD_W-1:0] prod_ff;
   logic [rpb_pkg::RPB_CHAN_W-1:0] diff_ff;

   logic [rpb_pkg::RPB_NUM_W-1:0]  numer;
   logic [25:0]                    scaled;
   logic [9:0]                     quot_est;
   logic [rpb_pkg::RPB_NUM_W:0]    quot_x255;
   logic [rpb_pkg::RPB_NUM_W:0]    remain;
   logic [9:0]                     quot;

   // stage one: pick operands (inverted for screen and bright overlay) and multiply
   always_comb begin
      opnd_x  = top_chan;
      opnd_y  = bottom_chan;
      form_in = rpb_pkg::RPB_FORM_MUL;
      unique case (op)
         rpb_pkg::RPB_OP_MULTIPLY: begin
            form_in = rpb_pkg::RPB_FORM_MUL;
         end
         rpb_pkg::RPB_OP_SUBTRACT: begin
            form_in = rpb_pkg::RPB_FORM_SUB;
         end
         rpb_pkg::RPB_OP_SCREEN: begin
            opnd_x  = rpb_pkg::RPB_FULL_SCALE - top_chan;
            opnd_y  = rpb_pkg::RPB_FULL_SCALE - bottom_chan;
            form_in = rpb_pkg::RPB_FORM_SCR;
         end
         rpb_pkg::RPB_OP_OVERLAY: begin
            if (bottom_chan > rpb_pkg::RPB_HALF_SCALE) begin
               opnd_x  = rpb_pkg::RPB_FULL_SCALE - top_chan;
               opnd_y  = rpb_pkg::RPB_FULL_SCALE - bottom_chan;
               form_in = rpb_pkg::RPB_FORM_OVL_HI;
            end else begin
               form_in = rpb_pkg::RPB_FORM_OVL_LO;
            end
         end
         default: begin
            form_in = rpb_pkg::RPB_FORM_MUL;
         end
      endcase
   end

   assign prod_in = {8'h00, opnd_x} * {8'h00, opnd_y};
   assign diff_in = (bottom_chan >= top_chan) ? (bottom_chan - top_chan) : '0;

   always_ff @(posedge clock) begin
      if (enable) begin
         form_ff <= form_in;
         prod_ff <= prod_in;
         diff_ff <= diff_in;
      end
   end

   // stage two: bias, then divide by 255 through the 257/65536 reciprocal
   always_comb begin
      case (form_ff) inside
         rpb_pkg::RPB_FORM_MUL,
         rpb_pkg::RPB_FORM_SCR:    numer = {1'b0, prod_ff} + 17'd127;
         rpb_pkg::RPB_FORM_OVL_LO: numer = {prod_ff, 1'b0};
         rpb_pkg::RPB_FORM_OVL_HI: numer = {prod_ff, 1'b0} + 17'd254;
         default:                  numer = '0;
      endcase
   end

   // estimate is exact or one short
   assign scaled    = 26'({numer, 8'h00}) + 26'(numer);
   assign quot_est  = scaled[25:16];
   assign quot_x255 = 18'({quot_est, 8'h00}) - 18'(quot_est);
   assign remain    = 18'(numer) - quot_x255;
   assign quot      = (remain >= 18'd255) ? (quot_est + 10'd1) : quot_est;

   always_comb begin
      case (form_ff) inside
         rpb_pkg::RPB_FORM_MUL,
         rpb_pkg::RPB_FORM_OVL_LO: result = quot[7:0];
         rpb_pkg::RPB_FORM_SCR,
         rpb_pkg::RPB_FORM_OVL_HI: result = rpb_pkg::RPB_FULL_SCALE - quot[7:0];
         rpb_pkg::RPB_FORM_SUB:    result = diff_ff;
         default:                  result = '0;
      endcase
   end

endmodule
`default_nettype wire

// ----- sv/rpb_merge.sv -----
`default_nettype none
module rpb_merge (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           push,
   input  wire logic [rpb_pkg::RPB_CHAN_W-1:0] blue,
   input  wire logic [rpb_pkg::RPB_CHAN_W-1:0] green,
   input  wire logic [rpb_pkg::RPB_CHAN_W-1:0] red,
   input  wire logic                           rsp_tready,
   output logic                                rsp_tvalid,
   output logic [23:0]                         rsp_tdata,
   output logic [rpb_pkg::RPB_CNT_W-1:0]       fill
);

   logic [23:0]                    store_ff [rpb_pkg::RPB_FIFO_DEPTH];
   logic [rpb_pkg::RPB_PTR_W-1:0]  wr_ptr_ff;
   logic [rpb_pkg::RPB_PTR_W-1:0]  wr_ptr_in;
   logic [rpb_pkg::RPB_PTR_W-1:0]  rd_ptr_ff;
   logic [rpb_pkg::RPB_PTR_W-1:0]  rd_ptr_in;
   logic [rpb_pkg::RPB_CNT_W-1:0]  count_ff;
   logic [rpb_pkg::RPB_CNT_W-1:0]  count_in;
   logic                           pop;

   assign rsp_tvalid = (count_ff != '0);
   assign rsp_tdata  = store_ff[rd_ptr_ff];
   assign fill       = count_ff;
   assign pop        = rsp_tvalid && rsp_tready;

   assign wr_ptr_in = push ? (wr_ptr_ff + rpb_pkg::RPB_PTR_W'(1)) : wr_ptr_ff;
   assign rd_ptr_in = pop  ? (rd_ptr_ff + rpb_pkg::RPB_PTR_W'(1)) : rd_ptr_ff;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + rpb_pkg::RPB_CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - rpb_pkg::RPB_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // lanes packed blue lowest
   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= {red, green, blue};
      end
   end

endmodule
`default_nettype wire

// ----- sv/rgb_pixel_blend_unit_core.sv -----
// rgb pixel blend unit
// req channel: one word per pixel pair, top and bottom bgr plus a blend mode
//   in tuser (0 multiply, 1 subtract, 2 screen, 3 overlay)
// rsp channel: one word per accepted req word, blended bgr, in order
// three lanes, one per colour, blend side by side; a merging stage packs
// their results into a four-word output queue
// a taken word is registered in the lane stage and then written into the queue; it shows
//   on rsp from the queue head; stage one is the 8x8 multiply, stage two the divide by 255
// throughput: one word per clock while rsp_tready stays high
// req_tready is worked out from reset and registered occupancy only (queue fill plus
//   the word in the lane stage), so a stalled receiver lets the block take
//   words until the queue is spoken for, then req_tready drops
// nothing is lost while rsp stalls; rsp_tdata holds until taken
// reset (synchronous, active high) empties the lanes and the queue and
//   holds req_tready low; there is no state beyond the pipeline
`default_nettype none
module rgb_pixel_blend_unit_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // top_blue, top_green, top_red, bottom_blue, bottom_green, bottom_red
   input  wire logic [47:0] req_tdata,
   // op
   input  wire logic [1:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // out_blue, out_green, out_red
   output logic [23:0]      rsp_tdata
);

   logic                                  accept;
   logic                                  stage_valid_ff;
   logic                                  stage_valid_in;
   rpb_pkg::op_type                       op;
   logic [rpb_pkg::RPB_CNT_W-1:0]         fill;
   logic [rpb_pkg::RPB_CNT_W-1:0]         occupancy;
   logic [rpb_pkg::RPB_CHAN_W-1:0]        lane_result [rpb_pkg::RPB_LANES];

   assign op        = rpb_pkg::op_type'(req_tuser);
   // every word in the lane stage already has a queue slot reserved
   assign occupancy  = fill + rpb_pkg::RPB_CNT_W'(stage_valid_ff);
   assign req_tready = !reset &&
                       (occupancy < rpb_pkg::RPB_CNT_W'(rpb_pkg::RPB_FIFO_DEPTH));
   assign accept     = req_tvalid && req_tready;

   assign stage_valid_in = accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   // one lane per colour; lane i takes byte i of top and byte i+3 of bottom
   for (genvar i = 0; i < rpb_pkg::RPB_LANES; i++) begin : g_lane
      rpb_lane u_lane (
         .clock       (clock),
         .enable      (accept),
         .op          (op),
         .top_chan    (req_tdata[i*rpb_pkg::RPB_CHAN_W +: rpb_pkg::RPB_CHAN_W]),
         .bottom_chan (req_tdata[(i+rpb_pkg::RPB_LANES)*rpb_pkg::RPB_CHAN_W +:
                                 rpb_pkg::RPB_CHAN_W]),
         .result      (lane_result[i])
      );
   end

   rpb_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .push       (stage_valid_ff),
      .blue       (lane_result[0]),
      .green      (lane_result[1]),
      .red        (lane_result[2]),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .fill       (fill)
   );

endmodule
`default_nettype wire

// ----- sv/rpb_checker.sv -----
`default_nettype none
`include "rgb_pixel_blend_unit_core_assert.svh"
module rpb_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic [47:0] req_tdata,
   input wire logic [1:0]  req_tuser,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [23:0] rsp_tdata
);

   logic req_take;
   logic take_ff;
   logic first_in_line;

   assign req_take      = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         take_ff <= 1'b0;
      end else begin
         take_ff <= req_take;
      end
   end

   // nothing queued and nothing in the lane stage ahead of this word
   assign first_in_line = req_take && !rsp_tvalid && !take_ff;

   // a stalled result word holds
   `RPB_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "rsp word changed under stall")

   // queue comes out of reset empty
   `RPB_ASSERT_NOW(a_rsp_empty_after_reset, clock, reset, $past(reset), !rsp_tvalid, "rsp valid straight after reset")

   // every taken word reaches rsp once through the lane stage
   `RPB_ASSERT_LATER2(a_latency, clock, reset, req_take, rsp_tvalid, "taken word did not reach rsp")

   // subtract result lands in the right lane for blue, the lowest byte
   `RPB_ASSERT_LATER2(a_subtract_blue, clock, reset, first_in_line && req_tuser == rpb_pkg::RPB_OP_SUBTRACT, rsp_tdata[7:0] == (($past(req_tdata[31:24], 2) >= $past(req_tdata[7:0], 2)) ? ($past(req_tdata[31:24], 2) - $past(req_tdata[7:0], 2)) : 8'd0), "subtract blue lane wrong")

endmodule

bind rgb_pixel_blend_unit_core rpb_checker u_rpb_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps
`default_nettype none
module testbench;

   localparam int LANE_MAX      = 255;   // full scale of one colour channel
   localparam int HOLD_CYCLES   = 80;    // long receiver hold-off
   localparam int TAIL_CYCLES   = 16;    // settle time after the last result
   localparam int WATCHDOG_MAX  = 2000;  // cycles with no word moving on either side
   localparam int REPORT_LINES  = 40;    // mismatch lines printed before going quiet

   // one pixel, blue in the low byte so it lines up with the tdata packing
   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_type;

   // one req word: blend mode plus the top and bottom pixels
   typedef struct packed {
      rpb_pkg::op_type mode;
      pixel_type       top;
      pixel_type       bottom;
   } pixel_pair_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata  = '0;
   logic [1:0]  req_tuser  = rpb_pkg::RPB_OP_MULTIPLY;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;

   pixel_pair_type pairs_to_send[$];  // filled by the sequencer, drained by the driver
   pixel_type      blended_due[$];    // predicted pixels, oldest first
   pixel_pair_type pair_on_bus;

   int send_idle_pct = 0;             // chance the driver leaves req idle in a cycle
   int rsp_stall_pct = 0;             // chance the receiver drops rsp_tready
   bit hold_req      = 1'b0;          // asks the hold-off process for a long stall
   int hold_count    = 0;
   int idle_cycles   = 0;
   int fail_count    = 0;
   int pixels_checked = 0;
   int mode_count[4] = '{0, 0, 0, 0};

   rgb_pixel_blend_unit_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // top bgr, bottom bgr
      .req_tuser  (req_tuser),   // op
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)    // blended bgr
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // prediction: each colour lane blended on its own in exact integers
   // ---------------------------------------------------------------------
   function automatic logic [7:0] blend_lane(rpb_pkg::op_type mode, logic [7:0] t,
                                             logic [7:0] b);
      int unsigned tv;
      int unsigned bv;
      int unsigned prod;
      int unsigned lane;
      tv = t;
      bv = b;
      case (mode)
         rpb_pkg::RPB_OP_MULTIPLY: begin
            // round(t*b/255); 255 is odd so there is never a tie
            lane = (2 * tv * bv + LANE_MAX) / (2 * LANE_MAX);
         end
         rpb_pkg::RPB_OP_SUBTRACT: begin
            lane = (bv >= tv) ? bv - tv : 0;
         end
         rpb_pkg::RPB_OP_SCREEN: begin
            prod = (LANE_MAX - tv) * (LANE_MAX - bv);
            lane = LANE_MAX - (2 * prod + LANE_MAX) / (2 * LANE_MAX);
         end
         default: begin
            // overlay truncates rather than rounds; the upper half uses a ceiling
            if (bv <= 127) begin
               lane = (2 * tv * bv) / LANE_MAX;
            end else begin
               prod = 2 * (LANE_MAX - tv) * (LANE_MAX - bv);
               lane = LANE_MAX - (prod + LANE_MAX - 1) / LANE_MAX;
            end
         end
      endcase
      return 8'(lane);
   endfunction

   function automatic pixel_type blend_pixel(pixel_pair_type pair);
      pixel_type px;
      px.blue  = blend_lane(pair.mode, pair.top.blue,  pair.bottom.blue);
      px.green = blend_lane(pair.mode, pair.top.green, pair.bottom.green);
      px.red   = blend_lane(pair.mode, pair.top.red,   pair.bottom.red);
      return px;
   endfunction

   // ---------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------
   // mostly uniform, with a fair share of the corner levels and the
   // overlay boundary either side of mid-scale
   function automatic logic [7:0] random_level();
      logic [7:0] corners[6] = '{8'd0, 8'd1, 8'd127, 8'd128, 8'd254, 8'd255};
      if ($urandom_range(0, 99) < 75) begin
         return 8'($urandom_range(0, 255));
      end
      return corners[$urandom_range(0, 5)];
   endfunction

   function automatic pixel_pair_type random_pair();
      pixel_pair_type pair;
      pair.mode         = rpb_pkg::op_type'($urandom_range(0, 3));
      pair.top.blue     = random_level();
      pair.top.green    = random_level();
      pair.top.red      = random_level();
      pair.bottom.blue  = random_level();
      pair.bottom.green = random_level();
      pair.bottom.red   = random_level();
      return pair;
   endfunction

   task automatic queue_pair(rpb_pkg::op_type mode,
                             logic [7:0] tb, logic [7:0] tg, logic [7:0] tr,
                             logic [7:0] bb, logic [7:0] bg, logic [7:0] br);
      pixel_pair_type pair;
      pair.mode         = mode;
      pair.top.blue     = tb;
      pair.top.green    = tg;
      pair.top.red      = tr;
      pair.bottom.blue  = bb;
      pair.bottom.green = bg;
      pair.bottom.red   = br;
      pairs_to_send = {pairs_to_send, pair};
   endtask

   // sender pauses here until every word has gone in and every result is back
   task automatic wait_drained();
      while (pairs_to_send.size() != 0 || req_tvalid || blended_due.size() != 0)
         @(negedge clock);
   endtask

   task automatic run_phase(int send_pct, int stall_pct, int words);
      send_idle_pct = send_pct;
      rsp_stall_pct = stall_pct;
      repeat (words) pairs_to_send = {pairs_to_send, random_pair()};
      wait_drained();
   endtask

   task automatic report_mismatch(string msg);
      if (fail_count < REPORT_LINES)
         $display("[%0t] mismatch: %s", $realtime, msg);
      fail_count++;
   endtask

   task automatic check_lane(string lane, logic [7:0] got, logic [7:0] want);
      if (got !== want)
         report_mismatch($sformatf("pixel %0d %s got %0d expected %0d",
                                   pixels_checked, lane, got, want));
   endtask

   // ---------------------------------------------------------------------
   // driver: one nonblocking write per signal per edge; a word is taken
   // at the edge where tvalid and tready are both high, and predicted then
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      bit busy;
      pixel_pair_type next_pair;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_tuser  <= rpb_pkg::RPB_OP_MULTIPLY;
      end else begin
         busy = req_tvalid;
         if (req_tvalid && req_tready) begin
            blended_due = {blended_due, blend_pixel(pair_on_bus)};
            mode_count[pair_on_bus.mode]++;
            busy = 1'b0;
         end
         // a word on offer stays put until taken
         if (!busy) begin
            if (pairs_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               next_pair   = pairs_to_send.pop_front();
               pair_on_bus = next_pair;
               req_tdata   <= {next_pair.bottom, next_pair.top};
               req_tuser   <= next_pair.mode;
               req_tvalid  <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // long receiver hold-off, counted here on its own
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset)
         hold_count <= 0;
      else if (hold_count == 0 && hold_req)
         hold_count <= HOLD_CYCLES;
      else if (hold_count != 0)
         hold_count <= hold_count - 1;
   end

   // ---------------------------------------------------------------------
   // monitor: compares each taken rsp word with the oldest prediction and
   // picks the receiver's readiness for the next edge
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      pixel_type got;
      pixel_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (blended_due.size() == 0) begin
               report_mismatch($sformatf("result %h with nothing expected", got));
            end else begin
               want = blended_due.pop_front();
               check_lane("blue",  got.blue,  want.blue);
               check_lane("green", got.green, want.green);
               check_lane("red",   got.red,   want.red);
               pixels_checked++;
            end
         end
         rsp_tready <= (hold_count == 0) && !hold_req &&
                       ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   // ---------------------------------------------------------------------
   // watchdog: too long with no word moving on either side ends the run
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == WATCHDOG_MAX) begin
         $display("watchdog: no word moved in %0d cycles", WATCHDOG_MAX);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // sequencer
   // ---------------------------------------------------------------------
   initial begin
      // directed words: extremes of every lane in every mode, the overlay
      // split either side of mid-scale, subtract at equality and underflow
      queue_pair(rpb_pkg::RPB_OP_MULTIPLY, 8'd0,   8'd255, 8'd0,   8'd0,   8'd255, 8'd255);
      queue_pair(rpb_pkg::RPB_OP_MULTIPLY, 8'd255, 8'd128, 8'd1,   8'd0,   8'd128, 8'd254);
      queue_pair(rpb_pkg::RPB_OP_SUBTRACT, 8'd100, 8'd200, 8'd0,   8'd100, 8'd50,  8'd255);
      queue_pair(rpb_pkg::RPB_OP_SUBTRACT, 8'd255, 8'd255, 8'd0,   8'd0,   8'd255, 8'd0);
      queue_pair(rpb_pkg::RPB_OP_SCREEN,   8'd0,   8'd255, 8'd0,   8'd0,   8'd255, 8'd255);
      queue_pair(rpb_pkg::RPB_OP_SCREEN,   8'd255, 8'd128, 8'd1,   8'd0,   8'd128, 8'd254);
      queue_pair(rpb_pkg::RPB_OP_OVERLAY,  8'd200, 8'd200, 8'd0,   8'd127, 8'd128, 8'd255);
      queue_pair(rpb_pkg::RPB_OP_OVERLAY,  8'd255, 8'd255, 8'd0,   8'd128, 8'd127, 8'd0);
      queue_pair(rpb_pkg::RPB_OP_OVERLAY,  8'd1,   8'd254, 8'd128, 8'd255, 8'd127, 8'd128);
      queue_pair(rpb_pkg::RPB_OP_OVERLAY,  8'd0,   8'd255, 8'd127, 8'd255, 8'd0,   8'd127);
      queue_pair(rpb_pkg::RPB_OP_MULTIPLY, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
      queue_pair(rpb_pkg::RPB_OP_SCREEN,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0);
      queue_pair(rpb_pkg::RPB_OP_SUBTRACT, 8'd1,   8'd254, 8'd127, 8'd0,   8'd255, 8'd128);

      // reset held from the start, released once and never raised again
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      wait_drained();

      // free flow, back-to-back words
      run_phase(0, 0, 300);

      // receiver holds off for a long stretch while words keep coming,
      // so the output queue fills and req_tready drops
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      hold_req      = 1'b1;
      repeat (40) pairs_to_send = {pairs_to_send, random_pair()};
      while (hold_count == 0) @(negedge clock);
      hold_req = 1'b0;
      wait_drained();

      run_phase(52, 0,  300);   // sender gaps
      run_phase(0,  52, 300);   // receiver stalls
      run_phase(6,  6,  300);   // light idling on both sides
      run_phase(0,  0,  100);   // free flow to close

      // let any stray word show itself before judging
      repeat (TAIL_CYCLES) @(negedge clock);

      $display("checked %0d blended pixels: multiply %0d, subtract %0d, screen %0d, overlay %0d",
               pixels_checked,
               mode_count[rpb_pkg::RPB_OP_MULTIPLY], mode_count[rpb_pkg::RPB_OP_SUBTRACT],
               mode_count[rpb_pkg::RPB_OP_SCREEN], mode_count[rpb_pkg::RPB_OP_OVERLAY]);
      $display("flow covered free running, a long rsp hold-off, sender gaps, rsp stalls and both");
      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("%0d mismatches", fail_count);
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
`default_nettype wire
